// ----- rtl/slcd_pkg.sv -----
// Shared types, codes and defaults for the sync/length/checksum deframer.
`default_nettype none
package slcd_pkg;

  // Defaults for the top-level parameters
  localparam int SYNC_LEN_DEF    = 2;
  localparam int MAX_PAYLOAD_DEF = 4096;

  // Fixed field widths
  localparam int BYTE_W   = 8;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 3;
  localparam int SYNC_W   = 32;
  localparam int LEN_LO_W = 16;

  // Verdict codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SYNC_BAD = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SUM_BAD  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EARLY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd4;

  // One received byte with its end-of-buffer flag
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              buffer_end;
  } item_t;

  // One result transaction plus a flag that the step produced one
  typedef struct packed {
    logic                has_result;
    logic                payload_valid;
    logic [BYTE_W-1:0]   payload_byte;
    logic [ID_W-1:0]     packet_id;
    logic                verdict_valid;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/slcd_in_reg.sv -----
// Input register stage: captures one incoming byte transaction.
`default_nettype none
module slcd_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    data_byte,
  input  wire logic          buffer_end,
  input  wire logic          take,
  output logic               item_valid,
  output slcd_pkg::item_t    item
);
  import slcd_pkg::*;

  // Hold off the sender only while a held item cannot move on
  assign in_stall = item_valid && !take;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.data_byte  <= data_byte;
      item.buffer_end <= buffer_end;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/slcd_core.sv -----
// Deframing state and single-step decode of one byte.
`default_nettype none
module slcd_core #(
  parameter int SYNC_LEN    = slcd_pkg::SYNC_LEN_DEF,
  parameter int MAX_PAYLOAD = slcd_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [slcd_pkg::SYNC_W-1:0]   cfg_data,
  input  wire logic                          take,
  input  wire slcd_pkg::item_t               item,
  output slcd_pkg::result_t                  res
);
  import slcd_pkg::*;

  localparam int LEFT_W = $clog2(MAX_PAYLOAD + 1);

  localparam logic [2:0] PH_SYNC    = 3'd0;
  localparam logic [2:0] PH_ID      = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CHECK   = 3'd4;
  localparam logic [2:0] PH_DRAIN   = 3'd5;

  localparam logic [2:0] SYNC_LAST = 3'(SYNC_LEN - 1);
  localparam logic [2:0] LEN_LAST  = 3'd7;

  logic [SYNC_W-1:0]   sync_pattern;
  logic [2:0]          phase, phase_next;
  logic [2:0]          field_index, field_index_next;
  logic [ID_W-1:0]     id_value, id_value_next;
  logic [LEN_LO_W-1:0] len_lo, len_lo_next;
  logic                len_hi, len_hi_next;
  logic [LEFT_W-1:0]   bytes_left, bytes_left_next;
  logic [BYTE_W-1:0]   running_sum, running_sum_next;

  logic [BYTE_W-1:0]   b;
  logic [BYTE_W-1:0]   expect_byte;
  logic                silent;
  logic                over;
  logic                pv, vv;
  logic [BYTE_W-1:0]   pb;
  logic [STATUS_W-1:0] st;
  logic [ID_W-1:0]     pid;

  assign b           = item.data_byte;
  assign expect_byte = sync_pattern[8*field_index[1:0] +: 8];

  // Decode one byte against the current phase
  always_comb begin
    phase_next       = phase;
    field_index_next = field_index;
    id_value_next    = id_value;
    len_lo_next      = len_lo;
    len_hi_next      = len_hi;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    silent           = 1'b0;
    over             = 1'b0;
    pv               = 1'b0;
    vv               = 1'b0;
    pb               = '0;
    st               = ST_OK;

    unique case (phase)
      PH_SYNC: begin
        if (b != expect_byte) begin
          vv = 1'b1;
          st = ST_SYNC_BAD;
        end else if (field_index == SYNC_LAST) begin
          phase_next       = PH_ID;
          field_index_next = '0;
        end else begin
          field_index_next = field_index + 3'd1;
        end
      end
      PH_ID: begin
        if (field_index[0]) begin
          id_value_next    = {b, id_value[7:0]};
          phase_next       = PH_LEN;
          field_index_next = '0;
        end else begin
          id_value_next    = {id_value[15:8], b};
          field_index_next = field_index + 3'd1;
        end
        running_sum_next = running_sum + b;
      end
      PH_LEN: begin
        if (field_index == LEN_LAST) begin
          field_index_next = '0;
          over = len_hi || (b != '0) || (len_lo > LEN_LO_W'(MAX_PAYLOAD));
          if (over) begin
            vv = 1'b1;
            st = ST_TOO_LONG;
          end else begin
            bytes_left_next = len_lo[LEFT_W-1:0];
            phase_next      = (len_lo != '0) ? PH_PAYLOAD : PH_CHECK;
          end
        end else begin
          field_index_next = field_index + 3'd1;
          if (field_index == 3'd0) begin
            len_lo_next[7:0] = b;
          end else if (field_index == 3'd1) begin
            len_lo_next[15:8] = b;
          end else begin
            len_hi_next = len_hi || (b != '0);
          end
        end
      end
      PH_PAYLOAD: begin
        pv               = 1'b1;
        pb               = b;
        running_sum_next = running_sum + b;
        bytes_left_next  = bytes_left - LEFT_W'(1);
        if (bytes_left == LEFT_W'(1)) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        vv = 1'b1;
        st = (b == ~running_sum) ? ST_OK : ST_SUM_BAD;
      end
      default: begin
        silent = 1'b1;
      end
    endcase

    // Id as seen by this byte, before any restart
    pid = id_value_next;

    // Close the buffer early, then pick drain or restart
    if (!silent && !vv && item.buffer_end) begin
      vv = 1'b1;
      st = ST_EARLY;
    end
    if (vv && !item.buffer_end) begin
      phase_next = PH_DRAIN;
    end
    if ((vv || silent) && item.buffer_end) begin
      phase_next       = PH_SYNC;
      field_index_next = '0;
      id_value_next    = '0;
      len_lo_next      = '0;
      len_hi_next      = 1'b0;
      bytes_left_next  = '0;
      running_sum_next = '0;
    end
  end

  // Pack the result transaction
  always_comb begin
    res.has_result    = pv || vv;
    res.payload_valid = pv;
    res.payload_byte  = pb;
    res.packet_id     = pid;
    res.verdict_valid = vv;
    res.status        = st;
  end

  // Advance the frame state on each consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SYNC;
      field_index <= '0;
      id_value    <= '0;
      len_lo      <= '0;
      len_hi      <= 1'b0;
      bytes_left  <= '0;
      running_sum <= '0;
    end else if (take) begin
      phase       <= phase_next;
      field_index <= field_index_next;
      id_value    <= id_value_next;
      len_lo      <= len_lo_next;
      len_hi      <= len_hi_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
    end
  end

  // Sync pattern register
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern <= '0;
    end else if (cfg_write) begin
      sync_pattern <= cfg_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/slcd_out_reg.sv -----
// Result register: holds one result transaction until the receiver takes it.
`default_nettype none
module slcd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire slcd_pkg::result_t res,
  output logic                   take,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   payload_valid,
  output logic [7:0]             payload_byte,
  output logic [15:0]            packet_id,
  output logic                   verdict_valid,
  output logic [2:0]             status
);
  import slcd_pkg::*;

  logic can_load;

  // Room when empty or when the held result leaves this cycle
  assign can_load = !out_valid || !out_stall;
  assign take     = item_valid && can_load;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= take && res.has_result;
    end
  end

  // Load the payload
  always_ff @(posedge clk) begin
    if (take && res.has_result) begin
      payload_valid <= res.payload_valid;
      payload_byte  <= res.payload_byte;
      packet_id     <= res.packet_id;
      verdict_valid <= res.verdict_valid;
      status        <= res.status;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sync_length_checksum_deframer.sv -----
// Top level of the sync/id/length/payload/checksum deframer.
//
// Input channel: one buffer byte per transaction (data_byte, buffer_end),
// handshaked with in_valid/in_stall. Output channel: one result transaction
// (payload_valid, payload_byte, packet_id, verdict_valid, status) on
// out_valid/out_stall, sent only for payload bytes and for the verdict.
// Configuration: sync_pattern is written when cfg_valid and cfg_ready are
// both high; cfg_ready is always high. Write it only while the block is idle.
//
// A byte is captured in the input register, decoded combinationally from
// there and its result is loaded into the output register when the byte is
// consumed, from where the receiver takes it.
// Throughput is one byte per cycle while the receiver does not stall; the
// decode is a single state update between the input and result registers.
// When the receiver stalls, the result holds and in_stall is high while
// the input register holds a byte. Bytes that give no result pass
// without using the output register. Reset clears the frame state, both
// register stages and sync_pattern; the block hunts for sync right away.
`default_nettype none
module sync_length_checksum_deframer #(
  parameter int SYNC_LEN    = slcd_pkg::SYNC_LEN_DEF,
  parameter int MAX_PAYLOAD = slcd_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] sync_pattern,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        buffer_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             payload_valid,
  output logic [7:0]       payload_byte,
  output logic [15:0]      packet_id,
  output logic             verdict_valid,
  output logic [2:0]       status
);
  import slcd_pkg::*;

  logic    item_valid;
  logic    take;
  item_t   item;
  result_t res;

  assign cfg_ready = 1'b1;

  // Input register
  slcd_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .buffer_end (buffer_end),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // Frame decode
  slcd_core #(
    .SYNC_LEN    (SYNC_LEN),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (sync_pattern),
    .take      (take),
    .item      (item),
    .res       (res)
  );

  // Result register
  slcd_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .res           (res),
    .take          (take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_valid (payload_valid),
    .payload_byte  (payload_byte),
    .packet_id     (packet_id),
    .verdict_valid (verdict_valid),
    .status        (status)
  );

endmodule
`default_nettype wire
